FILE: src/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

  localparam int unsigned POLL_LIMIT_DEF = 10;
  localparam int unsigned POLL_GAP_DEF   = 20;

  // host modes
  localparam logic [2:0] MODE_POWER  = 3'd3;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  // request kinds as held by the sequencer
  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_DAT   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_POWER = 2'd3;

  // bus actions
  localparam logic [2:0] ACT_CTRL   = 3'd0;
  localparam logic [2:0] ACT_DRIVE  = 3'd1;
  localparam logic [2:0] ACT_WAIT   = 3'd2;
  localparam logic [2:0] ACT_SAMPLE = 3'd3;
  localparam logic [2:0] ACT_FINISH = 3'd4;

  // nibble sources
  localparam logic [1:0] N_ZERO = 2'd0;
  localparam logic [1:0] N_HI   = 2'd1;
  localparam logic [1:0] N_LO   = 2'd2;
  localparam logic [1:0] N_CON  = 2'd3;

  // wait sources
  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_BYP  = 2'd1;
  localparam logic [1:0] W_GAP  = 2'd2;
  localparam logic [1:0] W_CON  = 2'd3;

  // program entry points in the action ROM
  localparam logic [6:0] P_POLL       = 7'd0;
  localparam logic [6:0] P_BYP_WR     = 7'd2;
  localparam logic [6:0] P_BYP_RD     = 7'd11;
  localparam logic [6:0] P_POWER      = 7'd14;
  localparam logic [6:0] P_SAMPLE     = 7'd34;
  localparam logic [6:0] P_GAP        = 7'd35;
  localparam logic [6:0] P_TIMEOUT    = 7'd37;
  localparam logic [6:0] P_HI         = 7'd40;
  localparam logic [6:0] P_LO_POST    = 7'd43;
  localparam logic [6:0] P_LO_RD      = 7'd46;
  localparam logic [6:0] P_LO_WR_BYP  = 7'd50;
  localparam logic [6:0] P_LO_WR_POLL = 7'd60;
  localparam logic [6:0] P_RHI        = 7'd70;
  localparam logic [6:0] P_RLO_BYP    = 7'd73;
  localparam logic [6:0] P_RLO_POLL   = 7'd76;

  typedef struct packed {
    logic       is_sample;
    logic [1:0] req;
    logic [7:0] byte_val;
    logic [3:0] nib;
  } item_t;

  typedef struct packed {
    logic [2:0]  act;
    logic        rs;
    logic        rs_x;     // RS follows the request (data vs command)
    logic        rw;
    logic        e;
    logic [1:0]  nsel;
    logic [3:0]  ncon;
    logic [1:0]  wsel;
    logic [10:0] wcon;
    logic        rdy_set;
    logic        rdy_clr;
  } uop_t;

  function automatic uop_t u_ctrl(input logic rs, input logic rs_x, input logic rw,
                                  input logic e);
    uop_t u;
    u      = '0;
    u.act  = ACT_CTRL;
    u.rs   = rs;
    u.rs_x = rs_x;
    u.rw   = rw;
    u.e    = e;
    return u;
  endfunction

  function automatic uop_t u_drive(input logic [1:0] nsel, input logic [3:0] ncon);
    uop_t u;
    u      = '0;
    u.act  = ACT_DRIVE;
    u.nsel = nsel;
    u.ncon = ncon;
    return u;
  endfunction

  function automatic uop_t u_wait(input logic [1:0] wsel, input logic [10:0] wcon);
    uop_t u;
    u      = '0;
    u.act  = ACT_WAIT;
    u.wsel = wsel;
    u.wcon = wcon;
    return u;
  endfunction

  function automatic uop_t u_plain(input logic [2:0] act);
    uop_t u;
    u     = '0;
    u.act = act;
    return u;
  endfunction

  function automatic uop_t lcdseq_rom(input logic [6:0] addr);
    uop_t u;
    u = '0;
    case (addr)
      7'd0, 7'd41, 7'd68, 7'd77: u = u_ctrl(1'b0, 1'b0, 1'b1, 1'b1);
      7'd1, 7'd13, 7'd34, 7'd36, 7'd42, 7'd49, 7'd69, 7'd72, 7'd78:
        u = u_plain(ACT_SAMPLE);
      7'd2, 7'd9, 7'd11, 7'd58, 7'd74: u = u_wait(W_BYP, 11'd0);
      7'd3, 7'd6, 7'd52, 7'd55, 7'd62, 7'd65: u = u_ctrl(1'b0, 1'b1, 1'b0, 1'b1);
      7'd4, 7'd53, 7'd63: u = u_drive(N_HI, 4'h0);
      7'd5, 7'd8, 7'd54, 7'd57, 7'd64, 7'd67: u = u_ctrl(1'b0, 1'b1, 1'b0, 1'b0);
      7'd7, 7'd56, 7'd66: u = u_drive(N_LO, 4'h0);
      7'd10, 7'd33, 7'd45, 7'd59, 7'd75: u = u_plain(ACT_FINISH);
      7'd12, 7'd48, 7'd71: u = u_ctrl(1'b1, 1'b0, 1'b1, 1'b1);
      7'd14: u = u_wait(W_CON, 11'd1600);
      7'd15, 7'd38: u = u_drive(N_ZERO, 4'h0);
      7'd16, 7'd19, 7'd23, 7'd27, 7'd31: u = u_ctrl(1'b0, 1'b0, 1'b0, 1'b0);
      7'd17, 7'd21, 7'd25, 7'd29: u = u_ctrl(1'b0, 1'b0, 1'b0, 1'b1);
      7'd18, 7'd22, 7'd26: u = u_drive(N_CON, 4'h3);
      7'd30: u = u_drive(N_CON, 4'h2);
      7'd20, 7'd28: u = u_wait(W_CON, 11'd500);
      7'd24: u = u_wait(W_CON, 11'd20);
      7'd32: u = u_wait(W_CON, 11'd10);
      7'd35, 7'd37: u = u_wait(W_GAP, 11'd0);
      7'd39: begin
        u = u_plain(ACT_FINISH);
        u.rdy_clr = 1'b1;
      end
      7'd40, 7'd43, 7'd46, 7'd50, 7'd60: u = u_ctrl(1'b0, 1'b0, 1'b1, 1'b0);
      7'd44, 7'd47, 7'd51, 7'd61: begin
        u = u_drive(N_ZERO, 4'h0);
        u.rdy_set = 1'b1;
      end
      7'd70, 7'd73, 7'd76: u = u_ctrl(1'b1, 1'b0, 1'b1, 1'b0);
      default: u = u_plain(ACT_FINISH);
    endcase
    return u;
  endfunction

endpackage

FILE: src/lcdseq_front.sv
`timescale 1ns / 1ps

module lcdseq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          mode_i,
  input  logic [7:0]          byte_value_i,
  input  logic [3:0]          pins_nibble_i,
  output logic                q_valid_o,
  output lcdseq_pkg::item_t   q_item_o,
  input  logic                q_pop_i
);
  import lcdseq_pkg::*;

  item_t      mem_q [2];
  item_t      item;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  // undefined modes are taken and dropped here
  assign push       = in_valid_i && in_ready_o && (mode_i <= MODE_SAMPLE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    item.is_sample = (mode_i == MODE_SAMPLE);
    item.req       = mode_i[1:0];
    item.byte_val  = byte_value_i;
    item.nib       = pins_nibble_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

endmodule

FILE: src/lcdseq_back.sv
`timescale 1ns / 1ps

module lcdseq_back #(
  parameter int unsigned POLL_LIMIT     = lcdseq_pkg::POLL_LIMIT_DEF,
  parameter int unsigned POLL_GAP_UNITS = lcdseq_pkg::POLL_GAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                q_valid_i,
  input  lcdseq_pkg::item_t   q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          action_o,
  output logic                reg_select_o,
  output logic                read_write_o,
  output logic                enable_level_o,
  output logic [3:0]          data_nibble_o,
  output logic [15:0]         wait_units_o,
  output logic [7:0]          read_byte_o,
  output logic                status_o,
  output logic                ready_flag_o,
  output logic                last_o
);
  import lcdseq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PRE_BF  = 4'd1;
  localparam logic [3:0] S_PRE_HI  = 4'd2;
  localparam logic [3:0] S_PRE_LO  = 4'd3;
  localparam logic [3:0] S_POST_BF = 4'd4;
  localparam logic [3:0] S_POST_HI = 4'd5;
  localparam logic [3:0] S_POST_LO = 4'd6;
  localparam logic [3:0] S_READ_HI = 4'd7;
  localparam logic [3:0] S_READ_LO = 4'd8;

  logic [15:0] bypass_q;
  logic [3:0]  step_q, step_d;
  logic [1:0]  pend_q, pend_d;
  logic [7:0]  held_q, held_d;
  logic [3:0]  poll_q, poll_d, poll_inc;
  logic [7:0]  asm_q, asm_d, asm_lo;
  logic        fin_st_q, fin_st_d;
  logic [7:0]  fin_byte_q, fin_byte_d;
  logic        rdy_q, rdy_emit;
  logic        busy_q;
  logic [6:0]  pc_q;
  logic        go;
  logic [6:0]  start;
  logic        byp_on, pend_read, pend_data;
  logic        emit, uop_last;
  uop_t        uop;

  logic [2:0]  act_q;
  logic        rs_q, rw_q, e_q, stat_q, rflag_q, last_q, oval_q;
  logic [3:0]  nib_q, nib_emit;
  logic [15:0] wait_q, wait_emit;
  logic [7:0]  rbyte_q;

  assign byp_on    = (bypass_q != 16'd0);
  assign pend_read = (pend_q == REQ_READ);
  assign pend_data = (pend_q == REQ_DAT);
  assign poll_inc  = poll_q + 4'd1;
  assign asm_lo    = {asm_q[7:4], q_item_i.nib};
  assign q_pop_o   = q_valid_i && !busy_q;

  // dispatch: classify the item against the bus state, pick a program
  always_comb begin
    step_d     = step_q;
    pend_d     = pend_q;
    held_d     = held_q;
    poll_d     = poll_q;
    asm_d      = asm_q;
    fin_st_d   = fin_st_q;
    fin_byte_d = fin_byte_q;
    go         = 1'b0;
    start      = P_SAMPLE;
    if (q_pop_o) begin
      if (q_item_i.is_sample) begin
        case (step_q)
          S_PRE_BF, S_POST_BF: begin
            go = 1'b1;
            if (!q_item_i.nib[3]) begin
              start  = P_SAMPLE;
              step_d = (step_q == S_POST_BF) ? S_POST_HI : S_PRE_HI;
            end else begin
              poll_d = poll_inc;
              if (poll_inc >= 4'(POLL_LIMIT)) begin
                start      = P_TIMEOUT;
                step_d     = S_IDLE;
                fin_st_d   = 1'b1;
                fin_byte_d = !pend_read ? 8'h00 :
                             (step_q == S_POST_BF) ? asm_q : 8'hFF;
              end else begin
                start = P_GAP;
              end
            end
          end
          S_PRE_HI, S_POST_HI: begin
            go     = 1'b1;
            start  = P_HI;
            step_d = (step_q == S_POST_HI) ? S_POST_LO : S_PRE_LO;
          end
          S_PRE_LO: begin
            go = 1'b1;
            if (pend_read) begin
              start  = P_LO_RD;
              step_d = S_READ_HI;
            end else if (byp_on) begin
              start      = P_LO_WR_BYP;
              step_d     = S_IDLE;
              fin_st_d   = 1'b0;
              fin_byte_d = 8'h00;
            end else begin
              start  = P_LO_WR_POLL;
              poll_d = 4'd0;
              step_d = S_POST_BF;
            end
          end
          S_POST_LO: begin
            go         = 1'b1;
            start      = P_LO_POST;
            step_d     = S_IDLE;
            fin_st_d   = 1'b0;
            fin_byte_d = pend_read ? asm_q : 8'h00;
          end
          S_READ_HI: begin
            go     = 1'b1;
            start  = P_RHI;
            asm_d  = {q_item_i.nib, 4'h0};
            step_d = S_READ_LO;
          end
          S_READ_LO: begin
            go    = 1'b1;
            asm_d = asm_lo;
            if (byp_on) begin
              start      = P_RLO_BYP;
              step_d     = S_IDLE;
              fin_st_d   = 1'b0;
              fin_byte_d = asm_lo;
            end else begin
              start  = P_RLO_POLL;
              poll_d = 4'd0;
              step_d = S_POST_BF;
            end
          end
          default: go = 1'b0;
        endcase
      end else if (step_q == S_IDLE) begin
        go     = 1'b1;
        pend_d = q_item_i.req;
        if (q_item_i.req == REQ_POWER) begin
          start      = P_POWER;
          fin_st_d   = 1'b0;
          fin_byte_d = 8'h00;
        end else begin
          held_d = q_item_i.byte_val;
          if (q_item_i.req == REQ_READ) asm_d = 8'h00;
          if (!byp_on) begin
            start  = P_POLL;
            poll_d = 4'd0;
            step_d = S_PRE_BF;
          end else if (q_item_i.req == REQ_READ) begin
            start  = P_BYP_RD;
            step_d = S_READ_HI;
          end else begin
            start      = P_BYP_WR;
            fin_st_d   = 1'b0;
            fin_byte_d = 8'h00;
          end
        end
      end
    end
  end

  // action sequencer
  assign uop      = lcdseq_rom(pc_q);
  assign emit     = busy_q && (!oval_q || out_ready_i);
  assign uop_last = (uop.act == ACT_SAMPLE) || (uop.act == ACT_FINISH);
  assign rdy_emit = uop.rdy_set ? 1'b1 : (uop.rdy_clr ? 1'b0 : rdy_q);

  always_comb begin
    case (uop.nsel)
      N_HI:    nib_emit = held_q[7:4];
      N_LO:    nib_emit = held_q[3:0];
      N_CON:   nib_emit = uop.ncon;
      default: nib_emit = 4'h0;
    endcase
    case (uop.wsel)
      W_BYP:   wait_emit = bypass_q;
      W_GAP:   wait_emit = 16'(POLL_GAP_UNITS);
      W_CON:   wait_emit = {5'd0, uop.wcon};
      default: wait_emit = 16'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 16'd0;
      step_q   <= S_IDLE;
      pend_q   <= REQ_CMD;
      held_q   <= 8'h00;
      poll_q   <= 4'd0;
      asm_q    <= 8'h00;
      rdy_q    <= 1'b0;
      busy_q   <= 1'b0;
      pc_q     <= P_POLL;
      oval_q   <= 1'b0;
    end else begin
      if (cfg_we_i) bypass_q <= cfg_wdata_i;
      step_q <= step_d;
      pend_q <= pend_d;
      held_q <= held_d;
      poll_q <= poll_d;
      asm_q  <= asm_d;
      if (go) begin
        busy_q <= 1'b1;
        pc_q   <= start;
      end else if (emit) begin
        pc_q <= pc_q + 7'd1;
        if (uop_last) busy_q <= 1'b0;
      end
      if (emit) begin
        rdy_q  <= rdy_emit;
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_st_q   <= fin_st_d;
    fin_byte_q <= fin_byte_d;
    if (emit) begin
      act_q   <= uop.act;
      rs_q    <= uop.rs_x ? pend_data : uop.rs;
      rw_q    <= uop.rw;
      e_q     <= uop.e;
      nib_q   <= nib_emit;
      wait_q  <= wait_emit;
      rbyte_q <= (uop.act == ACT_FINISH) ? fin_byte_q : 8'h00;
      stat_q  <= (uop.act == ACT_FINISH) ? fin_st_q : 1'b0;
      rflag_q <= rdy_emit;
      last_q  <= uop_last;
    end
  end

  assign out_valid_o    = oval_q;
  assign action_o       = act_q;
  assign reg_select_o   = rs_q;
  assign read_write_o   = rw_q;
  assign enable_level_o = e_q;
  assign data_nibble_o  = nib_q;
  assign wait_units_o   = wait_q;
  assign read_byte_o    = rbyte_q;
  assign status_o       = stat_q;
  assign ready_flag_o   = rflag_q;
  assign last_o         = last_q;

endmodule

FILE: src/char_lcd_nibble_bus_sequencer.sv
`timescale 1ns / 1ps

// Character LCD 4-bit bus sequencer. Host requests (mode 0 command write, 1 data
// write, 2 read, 3 power-up) turn into a stream of bus actions; pin samples asked
// for by a sample action come back as mode 4 items. Each item yields 0 to 20
// actions, one per cycle from the action ROM sequencer while the output is
// accepted; the item is first dispatched from a two-entry queue. Inputs are
// taken into the queue until it is full, while the sequencer works and while
// the last action waits on the output register. A nonzero bypass_delay
// replaces busy-flag polling with fixed waits of that length; write it only
// while no request is in progress.
module char_lcd_nibble_bus_sequencer #(
  parameter int unsigned POLL_LIMIT     = lcdseq_pkg::POLL_LIMIT_DEF,
  parameter int unsigned POLL_GAP_UNITS = lcdseq_pkg::POLL_GAP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  byte_value_i,
  input  logic [3:0]  pins_nibble_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic        reg_select_o,
  output logic        read_write_o,
  output logic        enable_level_o,
  output logic [3:0]  data_nibble_o,
  output logic [15:0] wait_units_o,
  output logic [7:0]  read_byte_o,
  output logic        status_o,
  output logic        ready_flag_o,
  output logic        last_o
);
  import lcdseq_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  lcdseq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .byte_value_i  (byte_value_i),
    .pins_nibble_i (pins_nibble_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  lcdseq_back #(
    .POLL_LIMIT     (POLL_LIMIT),
    .POLL_GAP_UNITS (POLL_GAP_UNITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .reg_select_o   (reg_select_o),
    .read_write_o   (read_write_o),
    .enable_level_o (enable_level_o),
    .data_nibble_o  (data_nibble_o),
    .wait_units_o   (wait_units_o),
    .read_byte_o    (read_byte_o),
    .status_o       (status_o),
    .ready_flag_o   (ready_flag_o),
    .last_o         (last_o)
  );

`ifndef SYNTHESIS
  a_last_ends_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (action_o == ACT_SAMPLE || action_o == ACT_FINISH)))
    else $error("last flag out of step with action");

  a_status_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o || read_byte_o != 8'h00) |-> action_o == ACT_FINISH)
    else $error("status or read byte outside finish");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but empty");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
